// ----- rtl/sgr_pkg.sv -----
package sgr_pkg;

    localparam int GLYPH_ROWS = 16;
    localparam int GLYPH_COLS = 8;

    // At most 64 runs per row: the scale is capped so that scale * columns stays in bound.
    localparam int MAX_RUNS   = 64;
    localparam int SCALE_LIM  = 8;
    localparam int SCALE_CAP  = (MAX_RUNS / GLYPH_COLS < SCALE_LIM) ?
                                (MAX_RUNS / GLYPH_COLS) : SCALE_LIM;

    localparam int CIDX_W     = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
    localparam int ADDR_W     = 20;
    localparam int PITCH_W    = 10;
    localparam int LINE_W     = 10;
    localparam int PADDR_W    = 3;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 10'd480;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic can_emit;
        logic emit_last;
    } status_t;

endpackage

// ----- rtl/sgr_regs.sv -----
module sgr_regs
    import sgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [PITCH_W-1:0] line_pitch
);

    logic [PITCH_W-1:0] pitch_reg;
    logic [PITCH_W-1:0] pitch_next;
    logic               hit;

    // The only register sits at byte address zero; every address with the top bit clear selects it.
    assign hit    = (paddr[PADDR_W-1] == 1'b0);
    assign pready = 1'b1;

    always_comb
    begin
        pitch_next = pitch_reg;
        if (psel && penable && pwrite && hit)
        begin
            pitch_next = pwdata[PITCH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= PITCH_RESET;
        end
        else
        begin
            pitch_reg <= pitch_next;
        end
    end

    assign prdata     = hit ? {{(32-PITCH_W){1'b0}}, pitch_reg} : 32'd0;
    assign line_pitch = pitch_reg;

endmodule

// ----- rtl/sgr_ctrl.sv -----
module sgr_ctrl
    import sgr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // A row that yields no runs is absorbed right here.
                    if (!status.drop)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.can_emit)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sgr_datapath.sv -----
module sgr_datapath
    import sgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [PITCH_W-1:0] line_pitch,
    input  logic [15:0]        row_bits,
    input  logic [3:0]         row_index,
    input  logic [8:0]         glyph_x,
    input  logic [8:0]         glyph_y,
    input  logic [15:0]        ink_color,
    input  logic [3:0]         scale,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  run_address,
    output logic [3:0]         run_length,
    output logic [15:0]        run_color,
    output logic               last_run
);

    function automatic logic [CIDX_W-1:0] first_col(input logic [GLYPH_COLS-1:0] v);
        logic [CIDX_W-1:0] k;
        k = '0;
        for (int i = GLYPH_COLS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                k = CIDX_W'(i);
            end
        end
        return k;
    endfunction

    logic [GLYPH_COLS-1:0] in_mask;
    logic [3:0]            scale_sat;

    logic [GLYPH_COLS-1:0] mask_reg;
    logic [GLYPH_COLS-1:0] remain_reg;
    logic [GLYPH_COLS-1:0] remain_next;
    logic [3:0]            scale_reg;
    logic [3:0]            len_reg;
    logic [15:0]           color_reg;
    logic [8:0]            gx_reg;
    logic [LINE_W-1:0]     line_reg;
    logic [ADDR_W-1:0]     base_reg;
    logic [3:0]            sline_reg;

    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [3:0]            out_len_reg;
    logic [15:0]           out_color_reg;
    logic                  out_last_reg;

    logic [CIDX_W-1:0]     col;
    logic [CIDX_W+3:0]     col_off;
    logic [ADDR_W-1:0]     addr_now;
    logic                  row_end;
    logic                  last_line;

    // Column zero of the glyph is the top bit of the row word.
    always_comb
    begin
        for (int k = 0; k < GLYPH_COLS; k++)
        begin
            in_mask[k] = row_bits[15 - k];
        end
    end

    assign scale_sat = (32'(scale) > SCALE_CAP) ? 4'(SCALE_CAP) : scale;

    assign col         = first_col(remain_reg);
    assign col_off     = (CIDX_W+4)'(col) * (CIDX_W+4)'(len_reg);
    assign addr_now    = base_reg + ADDR_W'(gx_reg) + ADDR_W'(col_off);
    assign remain_next = remain_reg & ~(GLYPH_COLS'(1) << col);
    assign row_end     = (remain_next == '0);
    assign last_line   = (sline_reg == scale_reg - 4'd1);

    assign status.drop      = (scale_sat == 4'd0) || (32'(row_index) >= GLYPH_ROWS) ||
                              (in_mask == '0);
    assign status.can_emit  = !out_valid_reg || out_ready;
    assign status.emit_last = row_end && last_line;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mask_reg   <= in_mask;
            remain_reg <= in_mask;
            scale_reg  <= scale_sat;
            len_reg    <= scale_sat + 4'd1;
            color_reg  <= ink_color;
            gx_reg     <= glyph_x;
            line_reg   <= LINE_W'(glyph_y) + LINE_W'(row_index) * LINE_W'(scale_sat);
            sline_reg  <= 4'd0;
        end
        if (cmd.mul)
        begin
            base_reg <= ADDR_W'(line_reg) * ADDR_W'(line_pitch);
        end
        if (cmd.emit)
        begin
            out_addr_reg  <= addr_now;
            out_len_reg   <= len_reg;
            out_color_reg <= color_reg;
            out_last_reg  <= row_end && last_line;
            if (row_end)
            begin
                // Next screen line: restart the columns one pitch further on.
                remain_reg <= mask_reg;
                sline_reg  <= sline_reg + 4'd1;
                base_reg   <= base_reg + ADDR_W'(line_pitch);
            end
            else
            begin
                remain_reg <= remain_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign run_address = out_addr_reg;
    assign run_length  = out_len_reg;
    assign run_color   = out_color_reg;
    assign last_run    = out_last_reg;

endmodule

// ----- rtl/scaled_glyph_row_rasterizer_unit.sv -----
// Scaled glyph row rasterizer.
// The input channel (in_valid/in_ready) takes one glyph row beat: the row word, its
// row index, the glyph origin, the ink color and the scale. The output channel
// (out_valid/out_ready) delivers framebuffer fill runs, one beat per run, scale lines
// of one run per set column each, with last_run marking the final run of the row.
// No set columns or a zero scale gives no beats at all; the scale is clamped to SCALE_CAP.
// The edge that accepts the row beat loads the row, the next one does the
// line-times-pitch multiply, and the run emitter then moves the first run into
// the output register once that register can take it.
// After that, it emits one run per cycle while the receiver keeps out_ready high.
// A new row is accepted only once the previous row's last run has been moved into
// the output register, which may still hold that beat.
// When the receiver stalls, the output register holds its beat unchanged and the
// run emitter waits; nothing is dropped.
// The APB port holds line_pitch at address 0; write it only while the block is idle.
// Reset (rst_n low, asynchronous) clears the handshake state, empties the output
// register and sets line_pitch to 480.
module scaled_glyph_row_rasterizer_unit
    import sgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        row_bits,
    input  logic [3:0]         row_index,
    input  logic [8:0]         glyph_x,
    input  logic [8:0]         glyph_y,
    input  logic [15:0]        ink_color,
    input  logic [3:0]         scale,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  run_address,
    output logic [3:0]         run_length,
    output logic [15:0]        run_color,
    output logic               last_run
);

    logic [PITCH_W-1:0] line_pitch;
    cmd_t               cmd;
    status_t            status;

    // Configuration register file.
    sgr_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .line_pitch (line_pitch)
    );

    // Sequencer: idle, multiply, then one run per cycle while the output register can take it, until the last one.
    sgr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Address generation, column scan and the output register.
    sgr_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .line_pitch  (line_pitch),
        .row_bits    (row_bits),
        .row_index   (row_index),
        .glyph_x     (glyph_x),
        .glyph_y     (glyph_y),
        .ink_color   (ink_color),
        .scale       (scale),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .run_address (run_address),
        .run_length  (run_length),
        .run_color   (run_color),
        .last_run    (last_run)
    );

endmodule

// ----- tb/testbench.sv -----
module testbench
    import sgr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The only register, line_pitch, sits at byte address 0 of the APB port.
    localparam logic [PADDR_W-1:0] REG_LINE_PITCH_ADDR = PADDR_W'(0);

    // The block is slow on purpose only in the sense that a row with every column set
    // at the largest scale takes 64 beats. Even if every row did that and every beat
    // sat through a long receiver stall, the run stays far below this count.
    localparam int unsigned CYCLE_LIMIT = 200_000;

    // Once the last expected run has been accepted, the block can still be chewing on
    // a row that makes no runs at all. Such a row is absorbed at the edge that accepts it,
    // so this many quiet cycles is more than enough before a register write or the end.
    localparam int unsigned SETTLE_CYCLES = 16;

    // One glyph row as the sender presents it.
    typedef struct packed {
        logic [15:0] bits;
        logic [3:0]  row_idx;
        logic [8:0]  gx;
        logic [8:0]  gy;
        logic [15:0] color;
        logic [3:0]  scale;
    } glyph_row_t;

    // One fill run as the block delivers it.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [3:0]        len;
        logic [15:0]       color;
        logic              last;
    } fill_run_t;

    // A row of the directed table. Where typed is set, the expected outcome is written
    // out by hand: no runs at all, or exactly the single run given. Every other row is
    // handed to the predictor.
    typedef struct packed {
        glyph_row_t glyph;
        logic       typed;
        logic       has_run;
        fill_run_t  run;
    } directed_row_t;

    // The hand-typed runs assume the reset pitch of 480.
    localparam int N_DIRECTED = 17;
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // Leftmost column at the origin, scale one: a single two-pixel run at address 0.
        '{'{16'h8000, 4'd0, 9'd0, 9'd0, 16'h0000, 4'd1}, 1'b1, 1'b1,
          '{20'd0, 4'd2, 16'h0000, 1'b1}},
        // Rightmost column of the last row at the far corner of the nominal screen:
        // line 319 + 15 = 334, so 334 * 480 + 479 + 7 * 2 = 160813.
        '{'{16'h0100, 4'd15, 9'd479, 9'd319, 16'hFFFF, 4'd1}, 1'b1, 1'b1,
          '{20'd160813, 4'd2, 16'hFFFF, 1'b1}},
        // An empty row gives nothing.
        '{'{16'h0000, 4'd3, 9'd10, 9'd20, 16'h1234, 4'd3}, 1'b1, 1'b0, '0},
        // Only the unused low byte set: still nothing.
        '{'{16'h00FF, 4'd1, 9'd5, 9'd5, 16'hABCD, 4'd2}, 1'b1, 1'b0, '0},
        // Zero scale means zero screen lines, so nothing either.
        '{'{16'hFF00, 4'd2, 9'd7, 9'd9, 16'h5A5A, 4'd0}, 1'b1, 1'b0, '0},
        '{'{16'hFFFF, 4'd15, 9'd511, 9'd511, 16'hFFFF, 4'd0}, 1'b1, 1'b0, '0},
        // Every column at the largest scale: the full 64 runs, every other field at its top.
        '{'{16'hFFFF, 4'd15, 9'd511, 9'd511, 16'hFFFF, 4'd8}, 1'b0, 1'b0, '0},
        // Scales above the cap are clamped to it.
        '{'{16'h8000, 4'd0, 9'd0, 9'd0, 16'h0001, 4'd15}, 1'b0, 1'b0, '0},
        '{'{16'h0100, 4'd7, 9'd100, 9'd50, 16'h8000, 4'd9}, 1'b0, 1'b0, '0},
        // Alternating column patterns, and the leftmost and rightmost columns alone.
        '{'{16'hAA00, 4'd5, 9'd33, 9'd44, 16'h5555, 4'd2}, 1'b0, 1'b0, '0},
        '{'{16'h5500, 4'd10, 9'd200, 9'd100, 16'hAAAA, 4'd3}, 1'b0, 1'b0, '0},
        '{'{16'h8100, 4'd0, 9'd0, 9'd0, 16'h00FF, 4'd1}, 1'b0, 1'b0, '0},
        // Second column of row one: line 3 + 1 = 4, so 4 * 480 + 2 + 1 * 2 = 1924.
        '{'{16'h4000, 4'd1, 9'd2, 9'd3, 16'hFF00, 4'd1}, 1'b1, 1'b1,
          '{20'd1924, 4'd2, 16'hFF00, 1'b1}},
        '{'{16'hFF00, 4'd8, 9'd256, 9'd256, 16'h0F0F, 4'd4}, 1'b0, 1'b0, '0},
        '{'{16'h1000, 4'd12, 9'd1, 9'd1, 16'hF0F0, 4'd7}, 1'b0, 1'b0, '0},
        '{'{16'hFFFF, 4'd0, 9'd0, 9'd0, 16'h7FFF, 4'd1}, 1'b0, 1'b0, '0},
        // Last glyph row at the origin: line 15, so 15 * 480 = 7200.
        '{'{16'h8000, 4'd15, 9'd0, 9'd0, 16'h0F0F, 4'd1}, 1'b1, 1'b1,
          '{20'd7200, 4'd2, 16'h0F0F, 1'b1}}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [15:0]        row_bits = '0;
    logic [3:0]         row_index = '0;
    logic [8:0]         glyph_x = '0;
    logic [8:0]         glyph_y = '0;
    logic [15:0]        ink_color = '0;
    logic [3:0]         scale = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ADDR_W-1:0]  run_address;
    logic [3:0]         run_length;
    logic [15:0]        run_color;
    logic               last_run;

    // Our own copy of the pitch register and the runs still owed by the block.
    logic [PITCH_W-1:0] pitch_model = PITCH_RESET;
    fill_run_t          pending_runs [$];

    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 50;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    scaled_glyph_row_rasterizer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row_bits    (row_bits),
        .row_index   (row_index),
        .glyph_x     (glyph_x),
        .glyph_y     (glyph_y),
        .ink_color   (ink_color),
        .scale       (scale),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .run_address (run_address),
        .run_length  (run_length),
        .run_color   (run_color),
        .last_run    (last_run)
    );

    always #1 clk = ~clk;

    // Watchdog: a hung handshake or runs that never show up end the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // The receiver drops out_ready at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Works out every run one glyph row should produce and queues them in order:
    // screen lines outermost, set columns left to right within a line.
    task automatic predict_row_runs(input glyph_row_t r);
        int unsigned eff_scale;
        int unsigned total;
        int unsigned made;
        int unsigned line;
        int unsigned addr;
        fill_run_t   run;
        eff_scale = (r.scale > SCALE_CAP) ? SCALE_CAP : r.scale;
        if (eff_scale == 0 || r.row_idx >= GLYPH_ROWS)
            return;
        total = eff_scale * $countones(r.bits[15 -: GLYPH_COLS]);
        made = 0;
        for (int unsigned s = 0; s < eff_scale; s++)
        begin
            line = r.gy + r.row_idx * eff_scale + s;
            for (int unsigned k = 0; k < GLYPH_COLS; k++)
            begin
                if (r.bits[15 - k])
                begin
                    made++;
                    // Pixels are scale+1 wide, so column k starts k*(scale+1) in.
                    addr = line * pitch_model + r.gx + k * (eff_scale + 1);
                    run.addr  = addr[ADDR_W-1:0];
                    run.len   = 4'(eff_scale + 1);
                    run.color = r.color;
                    run.last  = (made == total);
                    pending_runs.push_back(run);
                end
            end
        end
    endtask

    // Every accepted run beat is checked against the oldest run still owed.
    always @(posedge clk)
    begin : run_checker
        fill_run_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_runs.size() == 0)
            begin
                $error("run beat with none expected: run_address %0d", run_address);
                fail_count++;
            end
            else
            begin
                want = pending_runs.pop_front();
                if (run_address !== want.addr)
                begin
                    $error("run_address: expected %0d, actual %0d", want.addr, run_address);
                    fail_count++;
                end
                if (run_length !== want.len)
                begin
                    $error("run_length: expected %0d, actual %0d", want.len, run_length);
                    fail_count++;
                end
                if (run_color !== want.color)
                begin
                    $error("run_color: expected %h, actual %h", want.color, run_color);
                    fail_count++;
                end
                if (last_run !== want.last)
                begin
                    $error("last_run: expected %b, actual %b", want.last, last_run);
                    fail_count++;
                end
            end
        end
    end

    // Presents one row beat and returns at the edge where it is taken. Valid is left
    // high so that a row following straight on needs no second drive in one step.
    task automatic send_row(input glyph_row_t r);
        in_valid  <= 1'b1;
        row_bits  <= r.bits;
        row_index <= r.row_idx;
        glyph_x   <= r.gx;
        glyph_y   <= r.gy;
        ink_color <= r.color;
        scale     <= r.scale;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Random sender idling: each cycle idles with the phase's probability.
    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Holds off the sender until every owed run has come back. It waits on the clock
    // before it checks, so valid is never dropped and raised again within one step.
    task automatic drain_runs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_runs.size() != 0);
    endtask

    // Writes line_pitch with the block idle and reads it back.
    task automatic set_line_pitch(input logic [PITCH_W-1:0] value);
        logic [31:0] readback;
        drain_runs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_LINE_PITCH_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // The write lands at this edge; go straight into the read setup cycle.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== 32'(value))
        begin
            $error("line_pitch readback: expected %0d, actual %0d", value, readback);
            fail_count++;
        end
        pitch_model = value;
    endtask

    // Mostly well-formed rows: at least one used column and a scale inside the cap,
    // with random origin and color. The rest are zero scales, oversize scales that get
    // clamped, and rows whose used columns are all clear.
    function automatic glyph_row_t random_row();
        glyph_row_t r;
        r.bits    = 16'($urandom);
        r.row_idx = 4'($urandom);
        r.gx      = 9'($urandom);
        r.gy      = 9'($urandom);
        r.color   = 16'($urandom);
        if ($urandom_range(99) < 85)
        begin
            if (r.bits[15 -: GLYPH_COLS] == '0)
                r.bits[15 - $urandom_range(GLYPH_COLS - 1)] = 1'b1;
            if ($urandom_range(3) == 0)
                r.scale = 4'($urandom_range(5, SCALE_CAP));
            else
                r.scale = 4'($urandom_range(1, 4));
        end
        else
        begin
            case ($urandom_range(2))
                0: r.scale = 4'd0;
                1: r.scale = 4'($urandom_range(SCALE_CAP + 1, 15));
                default:
                begin
                    r.bits[15 -: GLYPH_COLS] = '0;
                    r.scale = 4'($urandom_range(1, SCALE_CAP));
                end
            endcase
        end
        return r;
    endfunction

    task automatic run_random_rows(input int unsigned n_rows);
        glyph_row_t r;
        for (int unsigned i = 0; i < n_rows; i++)
        begin
            // Now and then let the block run completely dry before the next row.
            if ($urandom_range(29) == 0)
                drain_runs();
            sender_gap();
            r = random_row();
            send_row(r);
            predict_row_runs(r);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: a lazy receiver and a mostly eager sender. The directed rows
        // run here first, at the reset pitch of 480.
        send_idle_pct = 8;
        recv_idle_pct = 50;
        foreach (DIRECTED_ROWS[i])
        begin
            sender_gap();
            send_row(DIRECTED_ROWS[i].glyph);
            if (DIRECTED_ROWS[i].typed)
            begin
                if (DIRECTED_ROWS[i].has_run)
                    pending_runs.push_back(DIRECTED_ROWS[i].run);
            end
            else
                predict_row_runs(DIRECTED_ROWS[i].glyph);
        end
        set_line_pitch(PITCH_W'(1023));
        run_random_rows(40);

        // Phase two: the roles swap, with the sender the one that keeps pausing.
        send_idle_pct = 50;
        recv_idle_pct = 8;
        set_line_pitch(PITCH_W'(1));
        run_random_rows(40);

        // Phase three: back to back on both sides, at a random pitch and then at zero,
        // where every screen line starts at the glyph's column.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_line_pitch(PITCH_W'($urandom_range(2, 1022)));
        run_random_rows(12);
        set_line_pitch(PITCH_W'(0));
        run_random_rows(12);

        drain_runs();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
